// ----- sv/rws_pkg.sv -----
package rws_pkg;

  // Default table depth and register reset value
  localparam int unsigned NUM_ENTRIES_DEF = 32;
  localparam logic [23:0] MAX_DELAY_RST   = 24'd86400;

  // Request modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_STARTED = 2'd0;
  localparam logic [1:0] KIND_STOPPED = 2'd1;
  localparam logic [1:0] KIND_REPORT  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  event_index;
    logic [31:0] now_seconds;
    logic [31:0] series_start;
    logic [31:0] series_end;
    logic [19:0] period_minutes;
    logic [19:0] length_minutes;
    logic        rewrite_window;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  entry_index;
    logic [33:0] next_check_ms;
    logic        last;
  } rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_EVAL,
    ST_DELAY,
    ST_MIN,
    ST_REPORT,
    ST_FRC_CALC,
    ST_FRC_WRITE
  } state_e;

endpackage

// ----- sv/recurring_window_scheduler_unit.sv -----
// Load request: no result; busy stays low.
// Forced start/stop on a loaded entry: one result, registered after the FRC_CALC and FRC_WRITE states.
// Tick: each used entry passes LOAD, DIV (the shared bit-serial divider that forms the
// window phase), EVAL, DELAY and MIN; unused entries are skipped in SCAN, then REPORT.
// Results appear as one-cycle strobes; the receiver cannot stall them.
// Reset clears control, valid and active flags and sets the delay bound to its default; table memories are not reset.
module recurring_window_scheduler_unit #(
  parameter int unsigned NUM_ENTRIES = rws_pkg::NUM_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rws_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output rws_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [23:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
  localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);

  // Multiply minutes by sixty
  function automatic logic [25:0] times_sixty(input logic [19:0] x);
    times_sixty = {x, 6'b0} - {4'b0, x, 2'b0};
  endfunction

  rws_pkg::state_e state_q, state_d;

  // Table memories
  logic [31:0] start_mem [NUM_ENTRIES];
  logic [31:0] end_mem   [NUM_ENTRIES];
  logic [19:0] per_mem   [NUM_ENTRIES];
  logic [19:0] len_mem   [NUM_ENTRIES];
  logic [31:0] rd_start_q, rd_end_q;
  logic [19:0] rd_per_q, rd_len_q;

  logic [NUM_ENTRIES-1:0] valid_q, active_q;
  logic [23:0]            max_delay_q;
  logic [23:0]            best_q;
  logic [CNT_W-1:0]       scan_q;
  logic [1:0]             mode_q;
  logic [4:0]             ev_q;
  logic [31:0]            now_q;
  logic                   rewrite_q;
  logic [25:0]            p60_q, l60_q;
  logic [31:0]            dvd_q;
  logic [25:0]            rem_q;
  logic [4:0]             bit_q;
  logic [25:0]            d0_q;
  logic                   dmax_q, pre_q;
  logic [31:0]            d_q;
  logic [31:0]            snew_q;
  logic                   rsp_valid_q;
  rws_pkg::rsp_t          rsp_q;

  // Decode request index
  logic [5:0]       req_idx6;
  logic [IDX_W-1:0] req_addr;
  logic             req_idx_ok;
  logic [7:0]       ev8;
  logic [IDX_W-1:0] ev_addr;
  logic [7:0]       scan8;
  logic [IDX_W-1:0] scan_addr;
  logic             scan_done;

  assign req_idx6   = {1'b0, req_i.event_index};
  assign req_addr   = req_idx6[IDX_W-1:0];
  assign req_idx_ok = (req_i.event_index != 5'd0) && (32'(req_idx6) < NUM_ENTRIES);
  assign ev8        = 8'(ev_q);
  assign ev_addr    = ev8[IDX_W-1:0];
  assign scan8      = 8'(scan_q);
  assign scan_addr  = scan8[IDX_W-1:0];
  assign scan_done  = 32'(scan_q) >= NUM_ENTRIES;

  logic accept, acc_load, acc_tick, acc_frc;
  assign accept   = start && !busy;
  assign acc_load = accept && (req_i.mode == rws_pkg::MODE_LOAD) && req_idx_ok;
  assign acc_tick = accept && (req_i.mode == rws_pkg::MODE_TICK);
  assign acc_frc  = accept && ((req_i.mode == rws_pkg::MODE_START) ||
                               (req_i.mode == rws_pkg::MODE_STOP)) &&
                    req_idx_ok && valid_q[req_addr];

  // Divider step and evaluation arithmetic
  logic [26:0] trial;
  logic        trial_ge;
  logic        m_lt_l, in_win;
  logic [32:0] now_plus_d0;
  logic [31:0] d_final;
  logic [25:0] len60;
  logic [31:0] s_calc;
  logic [32:0] end_sum;
  logic [31:0] end_new;
  logic [33:0] report_ms;

  assign trial       = {rem_q, dvd_q[31]};
  assign trial_ge    = trial >= {1'b0, p60_q};
  assign m_lt_l      = rem_q < l60_q;
  assign in_win      = (p60_q != 26'd0) && (rd_start_q < now_q) && (now_q < rd_end_q) && m_lt_l;
  assign now_plus_d0 = {1'b0, now_q} + 33'(d0_q);

  always_comb begin
    if (dmax_q) begin
      d_final = {8'b0, max_delay_q};
    end else if (pre_q) begin
      d_final = rd_start_q - now_q;
    end else if ({1'b0, rd_end_q} < now_plus_d0) begin
      d_final = rd_end_q - now_q;
    end else begin
      d_final = 32'(d0_q);
    end
  end

  // Rewritten start: now for a forced start, now minus the length for a forced stop
  assign len60     = times_sixty(rd_len_q);
  assign s_calc    = (mode_q == rws_pkg::MODE_START) ? now_q :
                     ((now_q >= 32'(len60)) ? (now_q - 32'(len60)) : 32'd0);
  assign end_sum   = {1'b0, snew_q} + 33'(l60_q);
  assign end_new   = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
  assign report_ms = 34'({1'b0, best_q} + 25'd1) * 34'd1000;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rws_pkg::ST_IDLE: begin
        if (acc_tick) begin
          state_d = rws_pkg::ST_SCAN;
        end else if (acc_frc) begin
          state_d = rws_pkg::ST_FRC_CALC;
        end
      end
      rws_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = rws_pkg::ST_REPORT;
        end else if (valid_q[scan_addr]) begin
          state_d = rws_pkg::ST_LOAD;
        end
      end
      rws_pkg::ST_LOAD:      state_d = rws_pkg::ST_DIV;
      rws_pkg::ST_DIV: begin
        if (bit_q == 5'd31) begin
          state_d = rws_pkg::ST_EVAL;
        end
      end
      rws_pkg::ST_EVAL:      state_d = rws_pkg::ST_DELAY;
      rws_pkg::ST_DELAY:     state_d = rws_pkg::ST_MIN;
      rws_pkg::ST_MIN:       state_d = rws_pkg::ST_SCAN;
      rws_pkg::ST_REPORT:    state_d = rws_pkg::ST_IDLE;
      rws_pkg::ST_FRC_CALC:  state_d = rws_pkg::ST_FRC_WRITE;
      rws_pkg::ST_FRC_WRITE: state_d = rws_pkg::ST_IDLE;
      default:               state_d = rws_pkg::ST_IDLE;
    endcase
  end

  // Memory port control
  logic             rd_en, wr_load, wr_frc, wr_end_frc;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    busy       = state_q != rws_pkg::ST_IDLE;
    rd_en      = 1'b0;
    rd_addr    = scan_addr;
    wr_load    = 1'b0;
    wr_frc     = 1'b0;
    wr_end_frc = 1'b0;
    case (state_q)
      rws_pkg::ST_IDLE: begin
        rd_en   = acc_frc;
        rd_addr = req_addr;
        wr_load = acc_load;
      end
      rws_pkg::ST_SCAN: begin
        rd_en = !scan_done && valid_q[scan_addr];
      end
      rws_pkg::ST_FRC_WRITE: begin
        wr_frc     = rewrite_q;
        wr_end_frc = rewrite_q && (rd_end_q <= snew_q);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Write and read the table
  always_ff @(posedge clk_i) begin
    if (wr_load) begin
      start_mem[req_addr] <= req_i.series_start;
      end_mem[req_addr]   <= req_i.series_end;
      per_mem[req_addr]   <= req_i.period_minutes;
      len_mem[req_addr]   <= req_i.length_minutes;
    end
    if (wr_frc) begin
      start_mem[ev_addr] <= snew_q;
    end
    if (wr_end_frc) begin
      end_mem[ev_addr] <= end_new;
    end
    if (rd_en) begin
      rd_start_q <= start_mem[rd_addr];
      rd_end_q   <= end_mem[rd_addr];
      rd_per_q   <= per_mem[rd_addr];
      rd_len_q   <= len_mem[rd_addr];
    end
  end

  // Hold state, flags, configuration and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rws_pkg::ST_IDLE;
      valid_q     <= '0;
      active_q    <= '0;
      max_delay_q <= rws_pkg::MAX_DELAY_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= ((state_q == rws_pkg::ST_EVAL) && (in_win != active_q[scan_addr])) ||
                     (state_q == rws_pkg::ST_REPORT) || (state_q == rws_pkg::ST_FRC_WRITE);
      if (cfg_we_i) begin
        max_delay_q <= cfg_wdata_i;
      end
      if (acc_load) begin
        valid_q[req_addr] <= req_i.length_minutes != 20'd0;
        if (req_i.length_minutes == 20'd0) begin
          active_q[req_addr] <= 1'b0;
        end
      end
      if (state_q == rws_pkg::ST_EVAL && in_win != active_q[scan_addr]) begin
        active_q[scan_addr] <= in_win;
      end
      if (state_q == rws_pkg::ST_FRC_WRITE) begin
        active_q[ev_addr] <= mode_q == rws_pkg::MODE_START;
      end
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= req_i.mode;
      ev_q      <= req_i.event_index;
      now_q     <= req_i.now_seconds;
      rewrite_q <= req_i.rewrite_window;
      best_q    <= max_delay_q;
      scan_q    <= CNT_W'(1);
    end
    case (state_q)
      rws_pkg::ST_SCAN: begin
        if (!scan_done && !valid_q[scan_addr]) begin
          scan_q <= scan_q + CNT_W'(1);
        end
      end
      rws_pkg::ST_LOAD: begin
        p60_q <= times_sixty(rd_per_q);
        l60_q <= times_sixty(rd_len_q);
        dvd_q <= now_q - rd_start_q;
        rem_q <= '0;
        bit_q <= '0;
      end
      rws_pkg::ST_DIV: begin
        rem_q <= trial_ge ? 26'(trial - {1'b0, p60_q}) : trial[25:0];
        dvd_q <= {dvd_q[30:0], 1'b0};
        bit_q <= bit_q + 5'd1;
      end
      rws_pkg::ST_EVAL: begin
        d0_q   <= m_lt_l ? (l60_q - rem_q) : (p60_q - rem_q);
        dmax_q <= (p60_q == 26'd0) || (now_q > rd_end_q);
        pre_q  <= rd_start_q > now_q;
        rsp_q  <= '{kind: in_win ? rws_pkg::KIND_STARTED : rws_pkg::KIND_STOPPED,
                    entry_index: scan8[4:0], next_check_ms: 34'd0, last: 1'b0};
      end
      rws_pkg::ST_DELAY: begin
        d_q <= d_final;
      end
      rws_pkg::ST_MIN: begin
        if (d_q < {8'b0, best_q}) begin
          best_q <= d_q[23:0];
        end
        scan_q <= scan_q + CNT_W'(1);
      end
      rws_pkg::ST_REPORT: begin
        rsp_q <= '{kind: rws_pkg::KIND_REPORT, entry_index: 5'd0,
                   next_check_ms: report_ms, last: 1'b1};
      end
      rws_pkg::ST_FRC_CALC: begin
        l60_q  <= len60;
        snew_q <= s_calc;
      end
      rws_pkg::ST_FRC_WRITE: begin
        rsp_q <= '{kind: (mode_q == rws_pkg::MODE_START) ? rws_pkg::KIND_STARTED
                                                          : rws_pkg::KIND_STOPPED,
                   entry_index: ev_q, next_check_ms: 34'd0, last: 1'b1};
      end
      default: begin
        bit_q <= bit_q;
      end
    endcase
  end

  // Drive results
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ENTRIES      = rws_pkg::NUM_ENTRIES_DEF;
  localparam realtime     CLK_PERIOD   = 8.0;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES  = 1200;
  localparam int unsigned PHASE_REQS   = 46;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start       = 1'b0;
  logic          busy;
  rws_pkg::req_t req_i       = '0;
  logic          rsp_valid_o;
  rws_pkg::rsp_t rsp_o;
  logic          cfg_we_i    = 1'b0;
  logic [23:0]   cfg_wdata_i = '0;

  recurring_window_scheduler_unit #(
    .NUM_ENTRIES(ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Window table as the block should hold it
  logic [31:0] tbl_start  [ENTRIES];
  logic [31:0] tbl_end    [ENTRIES];
  logic [19:0] tbl_period [ENTRIES];
  logic [19:0] tbl_len    [ENTRIES];
  logic        tbl_valid  [ENTRIES];
  logic        tbl_active [ENTRIES];
  logic [23:0] delay_cap;

  rws_pkg::rsp_t due_results[$];
  rws_pkg::req_t pending_reqs[$];
  int unsigned   fails      = 0;
  int unsigned   cycles     = 0;
  logic          took       = 1'b0;
  int unsigned   idle_left  = 0;
  int unsigned   burst_left = 0;

  // Stimulus-side view of time and of loaded windows
  logic [31:0] clock_now;
  logic [31:0] gen_start [ENTRIES];
  logic [31:0] gen_end   [ENTRIES];
  logic        gen_used  [ENTRIES];

  function automatic logic window_open(int e, longint unsigned now);
    longint unsigned per, len, s;
    per = 64'(tbl_period[e]) * 64'd60;
    len = 64'(tbl_len[e]) * 64'd60;
    s   = 64'(tbl_start[e]);
    if (per == 0) return 1'b0;
    return (s < now) && (now < 64'(tbl_end[e])) && (((now - s) % per) < len);
  endfunction

  // Seconds until this entry next changes state
  function automatic longint unsigned secs_to_change(int e, longint unsigned now);
    longint unsigned per, len, s, en, ph, d;
    per = 64'(tbl_period[e]) * 64'd60;
    len = 64'(tbl_len[e]) * 64'd60;
    s   = 64'(tbl_start[e]);
    en  = 64'(tbl_end[e]);
    if (per == 0 || now > en) return 64'(delay_cap);
    if (s > now) return s - now;
    ph = (now - s) % per;
    d  = (ph < len) ? (len - ph) : (per - ph);
    if (en < now + d) return en - now;
    return d;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [4:0] idx,
                                      logic [33:0] ms, logic last);
    rws_pkg::rsp_t res;
    res.kind          = kind;
    res.entry_index   = idx;
    res.next_check_ms = ms;
    res.last          = last;
    due_results       = {due_results, res};
  endfunction

  // Append one request to the pending list
  function automatic void add_req(rws_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Update the table for one accepted request and queue what it causes
  function automatic void apply_request(rws_pkg::req_t r);
    longint unsigned now, best, d, len, s, ne;
    logic            hit, idx_ok;
    int              idx;
    now    = 64'(r.now_seconds);
    idx    = int'(r.event_index);
    idx_ok = (idx != 0) && (idx < ENTRIES);
    case (r.mode)
      rws_pkg::MODE_LOAD: begin
        if (idx_ok) begin
          tbl_start[idx]  = r.series_start;
          tbl_end[idx]    = r.series_end;
          tbl_period[idx] = r.period_minutes;
          tbl_len[idx]    = r.length_minutes;
          if (r.length_minutes == '0) begin
            tbl_valid[idx]  = 1'b0;
            tbl_active[idx] = 1'b0;
          end else begin
            tbl_valid[idx] = 1'b1;
          end
        end
      end
      rws_pkg::MODE_TICK: begin
        best = 64'(delay_cap);
        for (int e = 1; e < ENTRIES; e++) begin
          if (tbl_valid[e]) begin
            hit = window_open(e, now);
            if (hit != tbl_active[e]) begin
              tbl_active[e] = hit;
              push_result(hit ? rws_pkg::KIND_STARTED : rws_pkg::KIND_STOPPED, 5'(e), '0,
                          1'b0);
            end
            d = secs_to_change(e, now);
            if (d < best) best = d;
          end
        end
        push_result(rws_pkg::KIND_REPORT, '0, 34'((best + 1) * 1000), 1'b1);
      end
      default: begin
        if (idx_ok && tbl_valid[idx]) begin
          tbl_active[idx] = (r.mode == rws_pkg::MODE_START);
          if (r.rewrite_window) begin
            len = 64'(tbl_len[idx]) * 64'd60;
            if (r.mode == rws_pkg::MODE_START) s = now;
            else s = (now >= len) ? now - len : 64'd0;
            tbl_start[idx] = 32'(s);
            if (64'(tbl_end[idx]) <= s) begin
              ne = s + len;
              if (ne > 64'hFFFF_FFFF) ne = 64'hFFFF_FFFF;
              tbl_end[idx] = 32'(ne);
            end
          end
          push_result((r.mode == rws_pkg::MODE_START) ? rws_pkg::KIND_STARTED
                                                       : rws_pkg::KIND_STOPPED,
                      r.event_index, '0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic rws_pkg::req_t mk_req(logic [1:0] mode, int unsigned idx,
                                           int unsigned now, int unsigned st,
                                           int unsigned en, int unsigned per,
                                           int unsigned len, int unsigned rw);
    rws_pkg::req_t r;
    r.mode           = mode;
    r.event_index    = 5'(idx);
    r.now_seconds    = now;
    r.series_start   = st;
    r.series_end     = en;
    r.period_minutes = 20'(per);
    r.length_minutes = 20'(len);
    r.rewrite_window = 1'(rw);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and bursts with none
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // Build one random request: mostly coherent loads, ticks and forces, some noise
  function automatic rws_pkg::req_t random_req();
    rws_pkg::req_t r;
    int unsigned   p, e;
    logic [19:0]   per, len;
    logic [31:0]   st, en;
    r = '0;
    r.rewrite_window = 1'($urandom);
    e = $urandom_range(1, ENTRIES - 1);
    if (clock_now > 32'hF000_0000) clock_now = $urandom_range(32'h0100_0000, 32'h8000_0000);
    p = $urandom_range(0, 99);
    if (p < 12) begin
      r.mode           = 2'($urandom);
      r.event_index    = 5'($urandom);
      r.now_seconds    = $urandom;
      r.series_start   = $urandom;
      r.series_end     = $urandom;
      r.period_minutes = 20'($urandom);
      r.length_minutes = 20'($urandom);
    end else if (p < 37) begin
      p = $urandom_range(0, 99);
      if (p < 5) per = '0;
      else if (p < 20) per = 20'($urandom);
      else per = 20'($urandom_range(1, 240));
      p = $urandom_range(0, 99);
      if (p < 10) len = '0;
      else if (p < 25) len = per + 20'($urandom_range(1, 50));
      else len = (per == '0) ? 20'($urandom_range(1, 30)) : 20'($urandom_range(1, 32'(per)));
      if ($urandom_range(0, 4) == 0) st = clock_now + $urandom_range(1, 5000);
      else st = clock_now - $urandom_range(0, 30000);
      if ($urandom_range(0, 9) == 0) en = 32'hFFFF_FFFF;
      else en = st + $urandom_range(0, 100000);
      r.mode           = rws_pkg::MODE_LOAD;
      r.event_index    = 5'(e);
      r.now_seconds    = $urandom;
      r.series_start   = st;
      r.series_end     = en;
      r.period_minutes = per;
      r.length_minutes = len;
      gen_start[e] = st;
      gen_end[e]   = en;
      gen_used[e]  = (len != '0);
    end else if (p < 80) begin
      r.mode = rws_pkg::MODE_TICK;
      p = $urandom_range(0, 99);
      if (p < 15 && gen_used[e]) begin
        r.now_seconds = (p < 8) ? gen_start[e] : gen_end[e];
        r.now_seconds = r.now_seconds + 32'($urandom_range(0, 2)) - 32'd1;
      end else begin
        if (p > 94) clock_now = clock_now + $urandom_range(0, 200000);
        else clock_now = clock_now + $urandom_range(0, 2400);
        r.now_seconds = clock_now;
      end
      r.event_index = 5'($urandom);
    end else begin
      r.mode        = ($urandom_range(0, 1) == 0) ? rws_pkg::MODE_START : rws_pkg::MODE_STOP;
      r.event_index = 5'(e);
      if ($urandom_range(0, 9) == 0) r.now_seconds = $urandom_range(0, 3000);
      else r.now_seconds = clock_now + $urandom_range(0, 600);
    end
    return r;
  endfunction

  // Drive requests at the falling edge; hold start while the block is busy
  always @(negedge clk_i) begin : drive_requests
    logic nxt_start;
    nxt_start = start;
    if (start && took) nxt_start = 1'b0;
    if (!nxt_start) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending_reqs.size() > 0) begin
        req_i     <= pending_reqs.pop_front();
        nxt_start = 1'b1;
        idle_left = pick_gap();
      end
    end
    start <= nxt_start;
  end

  // Check results against the oldest expectation, then take in new requests
  always @(posedge clk_i) begin : check_results
    rws_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d entry %0d ms %0d last %0d",
               rsp_o.kind, rsp_o.entry_index, rsp_o.next_check_ms, rsp_o.last);
        fails++;
      end else begin
        want = due_results.pop_front();
        if (rsp_o.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, rsp_o.kind);
          fails++;
        end
        if (rsp_o.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index, rsp_o.entry_index);
          fails++;
        end
        if (rsp_o.next_check_ms !== want.next_check_ms) begin
          $error("next_check_ms: expected %0d, got %0d",
                 want.next_check_ms, rsp_o.next_check_ms);
          fails++;
        end
        if (rsp_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_o.last);
          fails++;
        end
      end
    end
    took <= start && !busy;
    if (start && !busy) apply_request(req_i);
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Wait until every request is taken, every result is in and the block is idle
  task automatic settle();
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || start || due_results.size() > 0 || busy !== 1'b0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [23:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    delay_cap = v;
  endtask

  initial begin : stimulus
    logic [23:0] caps [5];
    for (int e = 0; e < ENTRIES; e++) begin
      tbl_valid[e]  = 1'b0;
      tbl_active[e] = 1'b0;
      gen_used[e]   = 1'b0;
    end
    delay_cap = rws_pkg::MAX_DELAY_RST;
    clock_now = $urandom_range(32'h0100_0000, 32'h8000_0000);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, reserved and unused entries, window edges, rewrites
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_LOAD, 0, '1, '1, '1, '1, '1, 1));
    add_req(mk_req(rws_pkg::MODE_START, 5, 1000, 0, 0, 0, 0, 1));
    add_req(mk_req(rws_pkg::MODE_LOAD, 1, 0, 1000, 100000, 60, 10, 0));
    add_req(mk_req(rws_pkg::MODE_LOAD, 31, 0, 32'hFFFF_0000, '1, '1, '1, 0));
    add_req(mk_req(rws_pkg::MODE_LOAD, 2, 0, 0, '1, 0, 5, 0));
    add_req(mk_req(rws_pkg::MODE_LOAD, 3, 0, 0, '1, 1, 2, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 1, 1000, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 1001, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 1600, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 100000, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_START, 1, 200000, 0, 0, 0, 0, 1));
    add_req(mk_req(rws_pkg::MODE_STOP, 1, 100, 0, 0, 0, 0, 1));
    add_req(mk_req(rws_pkg::MODE_STOP, 1, 5, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_START, 31, '1, 0, 0, 0, 0, 1));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, '1, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_LOAD, 1, 0, 7, 9, 3, 0, 0));
    add_req(mk_req(rws_pkg::MODE_STOP, 1, 50, 0, 0, 0, 0, 1));
    add_req(mk_req(rws_pkg::MODE_LOAD, 4, 0, 500, 400, 10, 1, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 450, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 12345, 0, 0, 0, 0, 0));
    settle();

    // Extremes of the delay bound
    write_cap(24'd1);
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 12346, 0, 0, 0, 0, 0));
    settle();
    write_cap(24'hFF_FFFF);
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_LOAD, 31, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(rws_pkg::MODE_TICK, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
    settle();

    // Random phases, each under its own delay bound
    caps[0] = rws_pkg::MAX_DELAY_RST;
    caps[1] = 24'd1;
    caps[2] = 24'hFF_FFFF;
    caps[3] = 24'($urandom_range(1, 24'hFF_FFFF));
    caps[4] = 24'($urandom_range(60, 7200));
    for (int ph = 0; ph < 5; ph++) begin
      write_cap(caps[ph]);
      repeat (PHASE_REQS) add_req(random_req());
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/rws_pkg.sv
sv/recurring_window_scheduler_unit.sv
tb/tb.sv
